// File: hw/rtl/dmcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmcl_pkg
// shared constants, op codes and types of the direct-mapped line store
// ----------------------------------------------------------------------------
package dmcl_pkg;

    // default number of lines
    localparam int DMCL_LINES = 16;

    localparam int WORD_W    = 16;
    localparam int WORDS     = 4;
    localparam int S_DATA_W  = 112;  // 106 payload bits padded to whole bytes
    localparam int M_DATA_W  = 96;   // 91 payload bits padded to whole bytes

    // header flag bits
    localparam int HDR_VALID = 0;
    localparam int HDR_DIRTY = 1;

    // op codes
    localparam logic [2:0] OP_LOOKUP    = 3'd0;
    localparam logic [2:0] OP_FILL      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_SET_DIRTY = 3'd3;
    localparam logic [2:0] OP_SET_VALID = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_words;

endpackage : dmcl_pkg
`default_nettype wire

// File: hw/rtl/direct_mapped_cache_lines_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// direct_mapped_cache_lines_top
// direct-mapped store of LINES lines, four 16-bit words plus a header each,
// with a recency age per line kept as a permutation of 0..LINES-1
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------
//  s        | in  | i_s_tvalid / o_s_tready      | i_s_tdata, one command
//  m        | out | o_m_tvalid / i_m_tready      | o_m_tdata, line state
//
//  timing: lookup time is set by the two-step remainder of block address
//    by LINES (reciprocal multiply, then multiply back and subtract), fill
//    time by the age sweep that visits every line once through the single
//    compare/subtract unit and the age memory's one read port
//  reset: synchronous, active low; per-line valid bits make the memories
//    read as their reset values at once, so no clearing pass is needed
//  stalls: a command is taken while the previous result still waits on m;
//    the last step waits until the result register is free
// ----------------------------------------------------------------------------
module direct_mapped_cache_lines_top
    import dmcl_pkg::*;
#(
    parameter int LINES = DMCL_LINES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // op[2:0] address[18:3] line_sel[22:19] word_sel[24:23] word_value[40:25]
    // flag_value[41] fill_word0[57:42] fill_word1[73:58] fill_word2[89:74]
    // fill_word3[105:90], zero pad above
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // hit[0] line_out[4:1] valid_out[5] dirty_out[6] start_address[22:7]
    // age_out[26:23] data_word0[42:27] data_word1[58:43] data_word2[74:59]
    // data_word3[90:75], zero pad above
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready
);

    localparam int LIW = (LINES > 1) ? $clog2(LINES) : 1;  // line index / age width
    localparam int UW  = LIW + 1;                           // compare / subtract unit width
    localparam int AGW = (LIW > 5) ? LIW : 5;
    localparam int LXW = (LIW > 4) ? LIW : 4;
    localparam int XW  = (LIW > 4) ? LIW : 4;
    localparam logic [8:0] LINES_9 = 9'(LINES);
    localparam logic [LIW:0] LINES_K = (LIW+1)'(LINES);

    // block address modulo LINES by a rounded-up reciprocal, exact for 14 bits
    localparam int BLK_W  = 14;
    localparam int PRD_W  = 2 * BLK_W + 1;
    localparam int RCP_SH = BLK_W + $clog2(LINES);
    localparam int RCP    = ((1 << RCP_SH) + LINES - 1) / LINES;
    localparam logic [BLK_W:0] RCP_K = (BLK_W+1)'(RCP);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;  // block address modulo LINES
    localparam logic [2:0] S_CUR  = 3'd2;  // fetch age of the line to fill
    localparam logic [2:0] S_AGE  = 3'd3;  // age sweep over all lines
    localparam logic [2:0] S_RD   = 3'd4;  // line and age read
    localparam logic [2:0] S_WR   = 3'd5;  // modify, write back, report

    // input field split
    logic [2:0]  s_op;
    logic [15:0] s_addr;
    logic [3:0]  s_sel;
    logic [1:0]  s_wsel;
    logic [15:0] s_wval;
    logic        s_flag;
    t_words      s_fill;
    logic        s_acc;
    logic        s_oor;

    assign s_op   = i_s_tdata[2:0];
    assign s_addr = i_s_tdata[18:3];
    assign s_sel  = i_s_tdata[22:19];
    assign s_wsel = i_s_tdata[24:23];
    assign s_wval = i_s_tdata[40:25];
    assign s_flag = i_s_tdata[41];
    assign s_fill = i_s_tdata[105:42];
    assign s_acc  = i_s_tvalid & o_s_tready;
    assign s_oor  = {5'b0, s_sel} >= LINES_9;

    // control state
    logic [2:0]     r_state;
    logic           r_mv;
    logic [LINES-1:0] r_lv;   // line (header + words) written since reset
    logic [LINES-1:0] r_av;   // age entry written since reset

    // command held for the whole op
    logic [2:0]     r_op;
    logic [15:0]    r_addr;
    logic [3:0]     r_sel;
    logic [1:0]     r_wsel;
    logic [15:0]    r_wval;
    logic           r_flag;
    t_words         r_fill;
    logic           r_oor;
    logic [LIW-1:0] r_idx;

    // sequencer datapath
    logic [BLK_W-1:0] r_blk;
    logic [PRD_W-1:0] r_prod;
    logic [3:0]     r_cnt;
    logic [LIW:0]   r_k;
    logic [LIW-1:0] r_cur;

    // memories and their registered read data
    logic [79:0]    mem_line [LINES];
    logic [LIW-1:0] mem_age  [LINES];
    logic [79:0]    r_line_q;
    logic           r_lv_q;
    logic [LIW-1:0] r_age_q;
    logic           r_av_q;

    logic [M_DATA_W-1:0] r_out;

    // compare / subtract unit of the age sweep
    logic [UW-1:0]  su_a;
    logic [UW-1:0]  su_b;
    logic [UW:0]    su_diff;
    logic           su_lt;

    logic [BLK_W-1:0]   quo;
    logic [BLK_W+8:0]   quo_x;
    logic [BLK_W-1:0]   rem_full;
    logic [LIW:0]   k_m1;
    logic [LIW-1:0] k_prev;
    logic [LIW-1:0] age_sw;
    logic [LIW-1:0] age_new;
    logic [LIW-1:0] age_raddr;
    logic           sweep_wr;
    logic           go;
    logic [XW-1:0]  sel_x;

    // quotient from the product, then remainder by multiply back and subtract
    assign quo      = BLK_W'(r_prod >> RCP_SH);
    assign quo_x    = {9'b0, quo} * {{BLK_W{1'b0}}, LINES_9};
    assign rem_full = r_blk - quo_x[BLK_W-1:0];
    assign k_m1   = r_k - 1'b1;
    assign k_prev = k_m1[LIW-1:0];
    assign age_sw = r_av_q ? r_age_q : k_prev;
    assign sel_x  = XW'(s_sel);

    always_comb begin
        su_a    = UW'(age_sw);
        su_b    = UW'(r_cur);
        su_diff = {1'b0, su_a} - {1'b0, su_b};
        su_lt   = su_diff[UW];
    end

    // ages below the filled line's age grow by one, the filled line gets 0
    always_comb begin
        if (k_prev == r_idx) begin
            age_new = '0;
        end else if (su_lt) begin
            age_new = age_sw + 1'b1;
        end else begin
            age_new = age_sw;
        end
    end

    assign sweep_wr  = (r_state == S_AGE) && (r_k != '0);
    assign age_raddr = ((r_state == S_AGE) && (r_k != LINES_K)) ? r_k[LIW-1:0] : r_idx;
    assign go        = !r_mv || i_m_tready;

    // modify step
    logic [15:0]    hdr_old;
    logic [15:0]    hdr_new;
    t_words         wrd_old;
    t_words         wrd_new;
    logic [LIW-1:0] age_cur;
    logic [AGW-1:0] age_x;
    logic [3:0]     age_sat;
    logic [LXW-1:0] idx_x;
    logic           hit;
    logic [M_DATA_W-1:0] n_out;

    always_comb begin
        hdr_old = r_lv_q ? r_line_q[15:0] : 16'h0000;
        wrd_old = r_lv_q ? r_line_q[79:16] : '0;
        hdr_new = hdr_old;
        wrd_new = wrd_old;
        unique case (r_op)
            OP_FILL: begin
                hdr_new = {r_addr[15:2], 2'b01};
                wrd_new = r_fill;
            end
            OP_WRITE: begin
                wrd_new[r_wsel] = r_wval;
            end
            OP_SET_DIRTY: begin
                hdr_new[HDR_DIRTY] = r_flag;
            end
            OP_SET_VALID: begin
                hdr_new[HDR_VALID] = r_flag;
            end
            default: begin
                hdr_new = hdr_old;
            end
        endcase
        hit     = (r_op == OP_LOOKUP) && (hdr_old[15:2] == r_addr[15:2])
                  && hdr_old[HDR_VALID];
        age_cur = r_av_q ? r_age_q : r_idx;
        age_x   = AGW'(age_cur);
        age_sat = (age_x > AGW'(15)) ? 4'hF : age_x[3:0];
        idx_x   = LXW'(r_idx);
        n_out   = '0;
        if (r_oor) begin
            n_out[4:1] = r_sel;
        end else begin
            n_out[0]     = hit;
            n_out[4:1]   = idx_x[3:0];
            n_out[5]     = hdr_new[HDR_VALID];
            n_out[6]     = hdr_new[HDR_DIRTY];
            n_out[22:7]  = {hdr_new[15:2], 2'b00};
            n_out[26:23] = age_sat;
            n_out[90:27] = wrd_new;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mv    <= 1'b0;
            r_lv    <= '0;
            r_av    <= '0;
        end else begin
            if (r_state == S_WR && go) begin
                r_mv <= 1'b1;
            end else if (i_m_tready) begin
                r_mv <= 1'b0;
            end
            if (sweep_wr) begin
                r_av[k_prev] <= 1'b1;
            end
            if (r_state == S_WR && go && !r_oor) begin
                r_lv[r_idx] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (s_op == OP_LOOKUP) begin
                            r_state <= S_MOD;
                        end else if (s_oor) begin
                            r_state <= S_WR;
                        end else if (s_op == OP_FILL) begin
                            r_state <= S_CUR;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_MOD: begin
                    if (r_cnt == 4'd1) begin
                        r_state <= S_RD;
                    end
                end
                S_CUR: r_state <= S_AGE;
                S_AGE: begin
                    if (r_k == LINES_K) begin
                        r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_WR;
                S_WR: begin
                    if (go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op   <= s_op;
            r_addr <= s_addr;
            r_sel  <= s_sel;
            r_wsel <= s_wsel;
            r_wval <= s_wval;
            r_flag <= s_flag;
            r_fill <= s_fill;
            r_oor  <= (s_op != OP_LOOKUP) && s_oor;
            r_idx  <= sel_x[LIW-1:0];
            r_blk  <= s_addr[15:2];
            r_cnt  <= '0;
            r_k    <= '0;
        end
        if (r_state == S_MOD) begin
            // first step multiplies by the reciprocal, second takes the remainder
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 4'd0) begin
                r_prod <= PRD_W'(r_blk) * PRD_W'(RCP_K);
            end else begin
                r_idx <= rem_full[LIW-1:0];
            end
        end
        if (r_state == S_AGE) begin
            r_k <= r_k + 1'b1;
            if (r_k == '0) begin
                r_cur <= r_av_q ? r_age_q : r_idx;
            end
        end
        if (r_state == S_WR && go) begin
            r_out <= n_out;
        end
    end

    // line memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && go && !r_oor) begin
            mem_line[r_idx] <= {wrd_new, hdr_new};
        end
        r_line_q <= mem_line[r_idx];
        r_lv_q   <= r_lv[r_idx];
    end

    // age memory
    always_ff @(posedge i_clk) begin
        if (sweep_wr) begin
            mem_age[k_prev] <= age_new;
        end
        r_age_q <= mem_age[age_raddr];
        r_av_q  <= r_av[age_raddr];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_out;

    // checks
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ({1'b0, r_idx} < LINES_K))
        else $error("line index left the line range");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AGE) |-> (r_k <= LINES_K))
        else $error("age sweep ran past the last line");

    a_lookup_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_op == OP_LOOKUP) |=> (r_state == S_MOD))
        else $error("lookup skipped the index step");

    a_out_from_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_WR))
        else $error("result appeared outside the write-back step");

    a_fill_young: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && r_op == OP_FILL && !r_oor) |-> (age_cur == '0))
        else $error("filled line is not the youngest");

endmodule : direct_mapped_cache_lines_top
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the direct-mapped line store: commands go in
// through the s stream, line state comes back on the m stream and is checked
// against a cycle-free predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb;
    import dmcl_pkg::*;

    localparam int LINES = DMCL_LINES;
    localparam int N_RANDOM = 1550;

    // op codes the block has no name for; they behave as a line read
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // command layout, lowest field in the lowest bits
    typedef struct packed {
        t_words      fill;
        logic        flag;
        logic [15:0] wval;
        logic [1:0]  wsel;
        logic [3:0]  sel;
        logic [15:0] addr;
        logic [2:0]  op;
    } cmd_t;

    // line state layout, lowest field in the lowest bits
    typedef struct packed {
        t_words      words;
        logic [3:0]  age;
        logic [15:0] start;
        logic        dirty;
        logic        valid;
        logic [3:0]  line;
        logic        hit;
    } line_state_t;

    typedef struct {
        cmd_t body;
        bit   drain_first;  // wait for every result before this transfer
    } queued_cmd_t;

    logic                clk;
    logic                rst_n;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;

    direct_mapped_cache_lines_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    // predicted contents of the store
    logic [15:0] header_mem [LINES];
    t_words      word_mem   [LINES];
    logic [7:0]  age_mem    [LINES];

    queued_cmd_t pending_cmds [$];
    line_state_t due_line_states [$];
    cmd_t        cur_cmd;
    bit          s_taken;
    int          send_gap;
    int          recv_stall;
    int          calm_left;
    int          cmds_total;
    int          cmds_taken;
    int          err_count;

    // stimulus-side memory of where each line was last filled from
    logic [15:0] filled_addr [LINES];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // applies one command to the predicted store, returns the line it reports
    function automatic line_state_t line_state_after(cmd_t c);
        line_state_t r;
        int          ln;
        logic [13:0] blk;
        logic [7:0]  cur;
        r = '0;
        if (c.op == OP_LOOKUP) begin
            blk = c.addr[15:2];
            ln = int'(blk) % LINES;
            r.hit = (header_mem[ln][15:2] == blk) && header_mem[ln][HDR_VALID];
        end else begin
            ln = int'(c.sel);
            if (ln >= LINES) begin
                r.line = c.sel;
                return r;
            end
            case (c.op)
                OP_FILL: begin
                    // everything younger than the filled line ages by one
                    cur = age_mem[ln];
                    for (int k = 0; k < LINES; k++) begin
                        if (age_mem[k] < cur) age_mem[k] = age_mem[k] + 8'd1;
                    end
                    age_mem[ln] = '0;
                    header_mem[ln] = {c.addr[15:2], 2'b01};
                    word_mem[ln] = c.fill;
                end
                OP_WRITE:     word_mem[ln][c.wsel] = c.wval;
                OP_SET_DIRTY: header_mem[ln][HDR_DIRTY] = c.flag;
                OP_SET_VALID: header_mem[ln][HDR_VALID] = c.flag;
                default: ;
            endcase
        end
        r.line  = ln[3:0];
        r.valid = header_mem[ln][HDR_VALID];
        r.dirty = header_mem[ln][HDR_DIRTY];
        r.start = header_mem[ln] & 16'hFFFC;
        r.age   = (age_mem[ln] > 8'd15) ? 4'd15 : age_mem[ln][3:0];
        r.words = word_mem[ln];
        return r;
    endfunction

    // mostly no gap, some short ones, a few long; now and then a calm stretch
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 8) begin
            calm_left = $urandom_range(30, 90);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 920) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // command with the given op, address and line select, random content in every other field
    function automatic cmd_t cmd_of(logic [2:0] op, logic [15:0] addr, logic [3:0] sel);
        cmd_t c;
        c = cmd_t'($bits(cmd_t)'({$urandom, $urandom, $urandom, $urandom}));
        c.op = op;
        c.addr = addr;
        c.sel = sel;
        return c;
    endfunction

    task automatic queue_cmd(cmd_t c, bit drain);
        queued_cmd_t q;
        q.body = c;
        q.drain_first = drain;
        pending_cmds.push_back(q);
    endtask

    // random command, mostly well-formed: fills land on their indexed line
    // and many lookups go to addresses filled before
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int          r;
        logic [3:0]  ln;
        ln = 4'($urandom_range(0, LINES - 1));
        c = cmd_of(OP_READ, 16'($urandom), ln);
        r = $urandom_range(0, 99);
        if (r < 35) begin
            c.op = OP_LOOKUP;
            if ($urandom_range(0, 1)) c.addr = filled_addr[ln] | 16'($urandom_range(0, 3));
        end else if (r < 55) begin
            c.op = OP_FILL;
            if ($urandom_range(0, 4) < 3) c.addr = (c.addr & 16'hFFC3) | {10'd0, ln, 2'd0};
            filled_addr[ln] = c.addr & 16'hFFFC;
        end else if (r < 70) begin
            c.op = OP_WRITE;
        end else if (r < 78) begin
            c.op = OP_SET_DIRTY;
        end else if (r < 86) begin
            c.op = OP_SET_VALID;
        end else if (r < 96) begin
            c.op = OP_READ;
        end else begin
            c.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        end
        return c;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // driver: presents the next command at the falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            // transfer still waiting, hold everything
        end else if (send_gap > 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 &&
                     (!pending_cmds[0].drain_first || due_line_states.size() == 0)) begin
            cur_cmd = pending_cmds[0].body;
            pending_cmds.delete(0);
            s_tdata <= S_DATA_W'(cur_cmd);
            s_tvalid <= 1'b1;
            send_gap = pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
        s_taken = 1'b0;
    end

    // result side back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_stall = pick_gap();
        end
    end

    // monitor: predicts on each command transfer, checks each result transfer
    always @(posedge clk) begin
        line_state_t want;
        line_state_t got;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                due_line_states.push_back(line_state_after(cur_cmd));
                s_taken = 1'b1;
                cmds_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = line_state_t'(m_tdata[$bits(line_state_t)-1:0]);
                if (due_line_states.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                end else begin
                    want = due_line_states.pop_front();
                    check_field("hit", 16'(want.hit), 16'(got.hit));
                    check_field("line_out", 16'(want.line), 16'(got.line));
                    check_field("valid_out", 16'(want.valid), 16'(got.valid));
                    check_field("dirty_out", 16'(want.dirty), 16'(got.dirty));
                    check_field("start_address", want.start, got.start);
                    check_field("age_out", 16'(want.age), 16'(got.age));
                    for (int w = 0; w < WORDS; w++) begin
                        check_field($sformatf("data_word%0d", w), want.words[w], got.words[w]);
                    end
                end
            end
        end
    end

    initial begin
        cmd_t c;
        int   waited;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        s_taken = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        calm_left = 0;
        cmds_taken = 0;
        err_count = 0;
        for (int k = 0; k < LINES; k++) begin
            header_mem[k] = '0;
            word_mem[k] = '0;
            age_mem[k] = 8'(k);
            filled_addr[k] = '0;
        end

        // directed part
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0000, 4'd0), 0);   // miss on cleared store
        queue_cmd(cmd_of(OP_LOOKUP, 16'hFFFF, 4'd3), 0);   // top address, last line
        queue_cmd(cmd_of(OP_READ, 16'h1234, 4'd15), 0);
        queue_cmd(cmd_of(OP_SPARE6, 16'hFFFF, 4'd7), 0);   // unused op reads
        queue_cmd(cmd_of(OP_SPARE7, 16'h0000, 4'd0), 0);
        c = cmd_of(OP_SET_VALID, 16'h0000, 4'd0);          // valid on a never-filled line
        c.flag = 1'b1;
        queue_cmd(c, 0);
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0003, 4'd9), 0);   // hits the zero tag
        c = cmd_of(OP_FILL, 16'hFFFF, 4'd15);              // oldest line, extreme words
        c.fill = {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
        queue_cmd(c, 0);
        queue_cmd(cmd_of(OP_LOOKUP, 16'hFFFC, 4'd0), 0);
        queue_cmd(cmd_of(OP_FILL, 16'h0010, 4'd0), 0);      // tag not matching its index
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0000, 4'd1), 0);   // valid line, other tag
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0010, 4'd2), 0);
        queue_cmd(cmd_of(OP_FILL, 16'h0013, 4'd4), 0);
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0011, 4'd0), 0);
        for (int w = 0; w < WORDS; w++) begin
            c = cmd_of(OP_WRITE, 16'h0000, 4'd4);
            c.wsel = 2'(w);
            c.wval = (w[0]) ? 16'h7FFF : ((w == 2) ? 16'h0000 : 16'h8000);
            if (w == 3) c.wval = 16'hFFFF;
            queue_cmd(c, 0);
        end
        c = cmd_of(OP_SET_DIRTY, 16'h0000, 4'd4);
        c.flag = 1'b1;
        queue_cmd(c, 0);
        c.flag = 1'b0;
        queue_cmd(c, 0);
        c = cmd_of(OP_SET_VALID, 16'h0000, 4'd4);          // sent on an idle block
        c.flag = 1'b0;
        queue_cmd(c, 1);
        queue_cmd(cmd_of(OP_LOOKUP, 16'h0010, 4'd0), 0);   // invalidated line misses
        c.flag = 1'b1;
        queue_cmd(c, 0);
        queue_cmd(cmd_of(OP_FILL, 16'h0000, 4'd4), 0);      // refill of the youngest line
        queue_cmd(cmd_of(OP_READ, 16'hFFFF, 4'd4), 0);

        // random part, with an occasional full drain ahead of a command
        filled_addr[0] = 16'h0010;
        filled_addr[4] = 16'h0000;
        filled_addr[15] = 16'hFFFC;
        for (int n = 0; n < N_RANDOM; n++) begin
            queue_cmd(random_cmd(), (n % 400) == 399);
        end
        cmds_total = pending_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmds_taken < cmds_total || due_line_states.size() != 0) @(posedge clk);
        // tail: any stray result still gets flagged
        for (waited = 0; waited < 60; waited++) @(posedge clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: direct_mapped_cache_lines_top.f
hw/rtl/dmcl_pkg.sv
hw/rtl/direct_mapped_cache_lines_top.sv
tb/tb.sv
